FILE: design/crnsd_pkg.sv
// Shared types and codes for the crank no-signal diagnostic.
// No dependencies; imported by the top level, crnsd_cfg and crnsd_core.
package crnsd_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned APB_W   = 32;
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [DATA_W-1:0] TIMER_MAX = 16'hFFFF;

    // Operation codes
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_KEYON       = 2'd1;
    localparam logic [1:0] OP_CRANK_STALL = 2'd2;
    localparam logic [1:0] OP_POWER_OFF   = 2'd3;

    // Engine states; anything above ES_OTHER acts as other
    localparam logic [2:0] ES_KEYON = 3'd0;
    localparam logic [2:0] ES_STALL = 3'd1;
    localparam logic [2:0] ES_CRANK = 3'd2;
    localparam logic [2:0] ES_RUN   = 3'd3;
    localparam logic [2:0] ES_OTHER = 3'd4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAP_DELTA   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IGN_DELTA   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NO_SIG_LIM  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RESET_LIM   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_SPEED  = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] map_delta_threshold;
        logic [DATA_W-1:0] ign_delta_threshold;
        logic [DATA_W-1:0] no_signal_limit;
        logic [DATA_W-1:0] reset_limit;
        logic [DATA_W-1:0] zero_speed_level;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [2:0]        engine_state;
        logic              cam_backup;
        logic              cam_level;
        logic [DATA_W-1:0] manifold_pressure;
        logic [DATA_W-1:0] ign_voltage;
        logic [DATA_W-1:0] ign_voltage_keyon;
        logic [DATA_W-1:0] engine_speed;
        logic              crank_failed;
    } item_t;

    typedef struct packed {
        logic test_failed;
        logic test_complete;
        logic enable_met;
        logic fail_condition;
    } result_t;

endpackage

FILE: design/crank_no_signal_diagnostic.sv
// Top level of the crank no-signal diagnostic: request/result registers and APB port.
// Depends on crnsd_pkg, crnsd_cfg and crnsd_core.

// Each request (tick, key-on capture, crank-to-stall reset or power-off reset)
// produces exactly one result carrying the failure latch, the sticky complete
// flag and the enable/fail flags of the latest tick. A request is captured in
// an input register, evaluated combinationally by the core and written to the
// result register. A new request is taken every cycle unless the input
// register holds, which it does only when the result register is full and
// not being taken. Thresholds and limits are written over APB at byte
// addresses 0x00 to 0x10 and must be set while no request is in flight.
module crank_no_signal_diagnostic (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [2:0]                    engine_state,
    input  logic                          cam_backup,
    input  logic                          cam_level,
    input  logic [crnsd_pkg::DATA_W-1:0]  manifold_pressure,
    input  logic [crnsd_pkg::DATA_W-1:0]  ign_voltage,
    input  logic [crnsd_pkg::DATA_W-1:0]  ign_voltage_keyon,
    input  logic [crnsd_pkg::DATA_W-1:0]  engine_speed,
    input  logic                          crank_failed,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          test_failed,
    output logic                          test_complete,
    output logic                          enable_met,
    output logic                          fail_condition,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crnsd_pkg::PADDR_W-1:0] paddr,
    input  logic [crnsd_pkg::APB_W-1:0]   pwdata,
    output logic [crnsd_pkg::APB_W-1:0]   prdata,
    output logic                          pready
);
    import crnsd_pkg::*;

    cfg_t    cfg;
    item_t   item_reg, item_next;
    logic    item_valid_reg;
    result_t res_reg, res_next;
    logic    res_valid_reg;
    logic    advance;

    // result register free or draining this cycle
    assign advance  = !res_valid_reg || out_ready;
    assign in_ready = !item_valid_reg || advance;

    assign item_next = '{operation:         operation,
                         engine_state:      engine_state,
                         cam_backup:        cam_backup,
                         cam_level:         cam_level,
                         manifold_pressure: manifold_pressure,
                         ign_voltage:       ign_voltage,
                         ign_voltage_keyon: ign_voltage_keyon,
                         engine_speed:      engine_speed,
                         crank_failed:      crank_failed};

    crnsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crnsd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (item_valid_reg && advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    // control: valid bits of the two registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= item_valid_reg;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
        if (item_valid_reg && advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign test_failed    = res_reg.test_failed;
    assign test_complete  = res_reg.test_complete;
    assign enable_met     = res_reg.enable_met;
    assign fail_condition = res_reg.fail_condition;

endmodule

FILE: design/crnsd_cfg.sv
// APB register file holding the five diagnostic thresholds and limits.
// Depends on crnsd_pkg.
module crnsd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crnsd_pkg::PADDR_W-1:0] paddr,
    input  logic [crnsd_pkg::APB_W-1:0]   pwdata,
    output logic [crnsd_pkg::APB_W-1:0]   prdata,
    output logic                         pready,
    output crnsd_pkg::cfg_t              cfg
);
    import crnsd_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;
    logic [DATA_W-1:0]    wdata;
    logic [DATA_W-1:0]    rd_val;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wdata  = pwdata[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MAP_DELTA:  cfg_reg.map_delta_threshold <= wdata;
                REG_IGN_DELTA:  cfg_reg.ign_delta_threshold <= wdata;
                REG_NO_SIG_LIM: cfg_reg.no_signal_limit     <= wdata;
                REG_RESET_LIM:  cfg_reg.reset_limit         <= wdata;
                REG_ZERO_SPEED: cfg_reg.zero_speed_level    <= wdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAP_DELTA:  rd_val = cfg_reg.map_delta_threshold;
            REG_IGN_DELTA:  rd_val = cfg_reg.ign_delta_threshold;
            REG_NO_SIG_LIM: rd_val = cfg_reg.no_signal_limit;
            REG_RESET_LIM:  rd_val = cfg_reg.reset_limit;
            REG_ZERO_SPEED: rd_val = cfg_reg.zero_speed_level;
            default:        rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_W-DATA_W){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

endmodule

FILE: design/crnsd_core.sv
// Diagnostic state and single-pass update logic for one request.
// Depends on crnsd_pkg.
module crnsd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  crnsd_pkg::item_t    item,
    input  crnsd_pkg::cfg_t     cfg,
    output crnsd_pkg::result_t  result
);
    import crnsd_pkg::*;

    logic              prev_cam_reg,    prev_cam_next;
    logic [DATA_W-1:0] press_keyon_reg, press_keyon_next;
    logic              enabled_reg,     enabled_next;
    logic              fail_reg,        fail_next;
    logic              latch_reg,       latch_next;
    logic              sticky_reg,      sticky_next;
    logic [DATA_W-1:0] ft_reg,          ft_next;
    logic              ft_run_reg,      ft_run_next;
    logic [DATA_W-1:0] ct_reg,          ct_next;
    logic              ct_run_reg,      ct_run_next;

    logic [DATA_W-1:0] ft_inc, ct_inc;
    logic [DATA_W-1:0] map_diff, ign_diff;
    logic              toggle_state, delta_state, by_toggle, by_delta, en, fl;
    logic              complete_now;

    always_comb
    begin
        ft_inc = (ft_run_reg && ft_reg != TIMER_MAX) ? ft_reg + 16'd1 : ft_reg;
        ct_inc = (ct_run_reg && ct_reg != TIMER_MAX) ? ct_reg + 16'd1 : ct_reg;

        map_diff = (press_keyon_reg > item.manifold_pressure)
                 ? press_keyon_reg - item.manifold_pressure
                 : item.manifold_pressure - press_keyon_reg;
        ign_diff = (item.ign_voltage_keyon > item.ign_voltage)
                 ? item.ign_voltage_keyon - item.ign_voltage
                 : item.ign_voltage - item.ign_voltage_keyon;

        toggle_state = item.engine_state == ES_KEYON || item.engine_state == ES_STALL
                    || item.engine_state == ES_CRANK || item.cam_backup;
        delta_state  = item.engine_state == ES_KEYON || item.engine_state == ES_CRANK
                    || item.cam_backup;
        by_toggle = toggle_state && (item.cam_level != prev_cam_reg);
        by_delta  = delta_state && (map_diff > cfg.map_delta_threshold)
                 && (ign_diff > cfg.ign_delta_threshold);
        en = by_toggle || by_delta;
        fl = en && ((item.engine_speed <= cfg.zero_speed_level) || item.crank_failed);
    end

    always_comb
    begin
        prev_cam_next    = prev_cam_reg;
        press_keyon_next = press_keyon_reg;
        enabled_next     = enabled_reg;
        fail_next        = fail_reg;
        latch_next       = latch_reg;
        sticky_next      = sticky_reg;
        ft_next          = ft_reg;
        ft_run_next      = ft_run_reg;
        ct_next          = ct_reg;
        ct_run_next      = ct_run_reg;
        complete_now     = 1'b0;

        case (item.operation)
            OP_KEYON:
            begin
                prev_cam_next    = item.cam_level;
                press_keyon_next = item.manifold_pressure;
            end
            OP_CRANK_STALL, OP_POWER_OFF:
            begin
                ft_next     = '0;
                ft_run_next = 1'b0;
                ct_next     = '0;
                ct_run_next = 1'b0;
                if (item.operation == OP_POWER_OFF)
                begin
                    sticky_next = 1'b0;
                end
            end
            default:
            begin
                ft_next       = ft_inc;
                ct_next       = ct_inc;
                enabled_next  = en;
                fail_next     = fl;
                prev_cam_next = item.cam_level;
                if (en)
                begin
                    ct_next     = '0;
                    ct_run_next = 1'b0;
                    if (fl && ft_inc < cfg.no_signal_limit)
                    begin
                        ft_run_next = 1'b1;
                    end
                    else
                    begin
                        // decision reached: fail when timer expired, else a pass
                        latch_next   = fl;
                        complete_now = 1'b1;
                        ft_next      = '0;
                        ft_run_next  = 1'b0;
                    end
                end
                else
                begin
                    if (ct_inc >= cfg.reset_limit)
                    begin
                        if (!item.cam_backup && item.engine_state == ES_RUN)
                        begin
                            latch_next = 1'b0;
                        end
                        ft_next     = '0;
                        ct_next     = '0;
                        ct_run_next = 1'b0;
                    end
                    else
                    begin
                        ct_run_next = 1'b1;
                    end
                    ft_run_next = 1'b0;
                end
                sticky_next = sticky_reg || complete_now;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cam_reg    <= 1'b0;
            press_keyon_reg <= '0;
            enabled_reg     <= 1'b0;
            fail_reg        <= 1'b0;
            latch_reg       <= 1'b0;
            sticky_reg      <= 1'b0;
            ft_reg          <= '0;
            ft_run_reg      <= 1'b0;
            ct_reg          <= '0;
            ct_run_reg      <= 1'b0;
        end
        else if (step)
        begin
            prev_cam_reg    <= prev_cam_next;
            press_keyon_reg <= press_keyon_next;
            enabled_reg     <= enabled_next;
            fail_reg        <= fail_next;
            latch_reg       <= latch_next;
            sticky_reg      <= sticky_next;
            ft_reg          <= ft_next;
            ft_run_reg      <= ft_run_next;
            ct_reg          <= ct_next;
            ct_run_reg      <= ct_run_next;
        end
    end

    assign result.test_failed    = latch_next;
    assign result.test_complete  = sticky_next;
    assign result.enable_met     = enabled_next;
    assign result.fail_condition = fail_next;

endmodule

FILE: design/crnsd_checker.sv
// Port-level assertions for the crank no-signal diagnostic, bound to the top level.
// Depends on crank_no_signal_diagnostic ports only.
module crnsd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic test_failed,
    input logic test_complete,
    input logic enable_met,
    input logic fail_condition,
    input logic pready
);

    // a fail condition is only ever reported on an enabled tick
    a_fail_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!fail_condition || enable_met))
        else $error("fail_condition without enable_met");

    // requests are refused only while a result waits to be taken
    a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with empty result register");

    // a request taken into an empty pipe shows a result through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
        else $error("result missing after request");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(test_failed)
            && $stable(test_complete) && $stable(enable_met)
            && $stable(fail_condition)))
        else $error("result changed while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind crank_no_signal_diagnostic crnsd_checker u_crnsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .test_failed    (test_failed),
    .test_complete  (test_complete),
    .enable_met     (enable_met),
    .fail_condition (fail_condition),
    .pready         (pready)
);
